### hdl/pngunf_pkg.sv
package pngunf_pkg;

    localparam int BYTE_W           = 8;
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_CHANNELS = 3;

    // Configuration register widths and the write port.
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLOR  = 2'd2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // Left, upper and upper-left neighbors of the byte being rebuilt.
    typedef struct packed {
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] up;
        logic [BYTE_W-1:0] up_left;
    } t_neighbors;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              last_of_image;
        logic              bad_filter;
    } t_result;

endpackage

### hdl/pngunf_byte_if.sv
interface pngunf_byte_if;
    logic                          valid;
    logic                          ready;
    logic [pngunf_pkg::BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

### hdl/pngunf_pix_if.sv
interface pngunf_pix_if;
    logic                          valid;
    logic                          ready;
    logic [pngunf_pkg::BYTE_W-1:0] pixel_byte;
    logic                          last_of_image;
    logic                          bad_filter;

    modport source (output valid, output pixel_byte, output last_of_image,
                    output bad_filter, input ready);
    modport sink   (input valid, input pixel_byte, input last_of_image,
                    input bad_filter, output ready);
endinterface

### hdl/pngunf_predictor.sv
module pngunf_predictor (
    input  pngunf_pkg::t_filter               i_filter,
    input  pngunf_pkg::t_neighbors            i_nb,
    input  logic [pngunf_pkg::BYTE_W-1:0]     i_byte,
    output logic [pngunf_pkg::BYTE_W-1:0]     o_value
);

    logic signed [9:0]             p;
    logic signed [9:0]             pa;
    logic signed [9:0]             pb;
    logic signed [9:0]             pc;
    logic [pngunf_pkg::BYTE_W-1:0] paeth;
    logic [pngunf_pkg::BYTE_W:0]   avg_sum;
    logic [pngunf_pkg::BYTE_W-1:0] pred;

    always_comb begin
        p  = $signed({2'b00, i_nb.left}) + $signed({2'b00, i_nb.up})
           - $signed({2'b00, i_nb.up_left});
        pa = p - $signed({2'b00, i_nb.left});
        pb = p - $signed({2'b00, i_nb.up});
        pc = p - $signed({2'b00, i_nb.up_left});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;

        // Ties go to left first, then to up.
        if (pa <= pb && pa <= pc) begin
            paeth = i_nb.left;
        end else if (pb <= pc) begin
            paeth = i_nb.up;
        end else begin
            paeth = i_nb.up_left;
        end

        avg_sum = {1'b0, i_nb.left} + {1'b0, i_nb.up};

        case (i_filter)
            pngunf_pkg::FILT_SUB:   pred = i_nb.left;
            pngunf_pkg::FILT_UP:    pred = i_nb.up;
            pngunf_pkg::FILT_AVG:   pred = avg_sum[pngunf_pkg::BYTE_W:1];
            pngunf_pkg::FILT_PAETH: pred = paeth;
            default:                pred = '0;
        endcase

        o_value = i_byte + pred;
    end

endmodule

### hdl/pngunf_row_store.sv
module pngunf_row_store #(
    parameter int DEPTH  = pngunf_pkg::DEF_MAX_WIDTH * pngunf_pkg::DEF_MAX_CHANNELS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ADDR_W-1:0]             i_waddr,
    input  logic [pngunf_pkg::BYTE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]             i_raddr,
    output logic [pngunf_pkg::BYTE_W-1:0] o_rdata
);

    logic [pngunf_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [pngunf_pkg::BYTE_W-1:0] r_rdata;
    logic [pngunf_pkg::BYTE_W-1:0] r_fwd_data;
    logic                          r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= mem[i_raddr];
        // A read of the address being written returns the new byte.
        r_fwd      <= i_we && (i_waddr == i_raddr);
        r_fwd_data <= i_wdata;
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

### hdl/png_scanline_unfilter.sv
// PNG scanline filter reconstruction for 8-bit grayscale and RGB images.
// The input channel carries the decompressed image stream, one word per
// byte: each row opens with a filter-type word, which yields no result,
// and the row's filtered data words follow. Every data word yields one
// result word on the output channel: the rebuilt sample, a flag on the
// last byte of the image, and a bad-filter flag. A filter type above
// Paeth yields a single bad-filter word, and the rest of that image is
// counted but silently dropped. Images follow one another back to back.
// Width, height and color mode are written through the configuration port
// while the stream is idle; they take effect on the next byte.
// The result word is registered after input acceptance. Throughput is one
// byte per cycle while input ready is high: the upper byte of each column
// is read ahead into the row memory's output register, at the address of the
// column that the next byte will use, so the memory's single read port
// and the combinational reconstruction path set the rate.
// Reset clears the position counters and the output; the row memory is
// not cleared, since the first row of every image never uses what it reads.
// When the receiver stalls, one result word parks in a skid register, and
// input ready drops only once that register is also full.
module png_scanline_unfilter #(
    parameter int MAX_WIDTH    = pngunf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = pngunf_pkg::DEF_MAX_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pngunf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pngunf_byte_if.sink                       i_byte_if,
    pngunf_pix_if.source                      o_pix_if
);

    // Row memory holds one full row of samples.
    localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int SLOT_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WREG_MAX  = (1 << pngunf_pkg::WIDTH_REG_W) - 1;
    localparam int WIDTH_CAP = (MAX_WIDTH < WREG_MAX) ? MAX_WIDTH : WREG_MAX;
    localparam int BW        = pngunf_pkg::BYTE_W;
    localparam int HW        = pngunf_pkg::HEIGHT_REG_W;

    // Configuration registers.
    logic [pngunf_pkg::WIDTH_REG_W-1:0] r_image_width;
    logic [HW-1:0]                      r_image_height;
    logic                               r_color_mode;

    // Position and row state.
    logic [ADDR_W-1:0]   r_col;
    logic [SLOT_W-1:0]   r_col_mod;
    logic [HW-1:0]       r_row;
    pngunf_pkg::t_filter r_row_filter;
    logic                r_await;
    logic                r_failed;
    logic [BW-1:0]       r_left    [MAX_CHANNELS];
    logic [BW-1:0]       r_up_left [MAX_CHANNELS];

    // Output register and skid register.
    pngunf_pkg::t_result r_out;
    logic                r_out_valid;
    pngunf_pkg::t_result r_skid;
    logic                r_skid_valid;

    logic                               accept;
    logic                               multi;
    logic [pngunf_pkg::WIDTH_REG_W-1:0] eff_width;
    logic [HW-1:0]                      eff_height;
    logic [LEN_W-1:0]                   row_len;
    logic                               end_row;
    logic                               end_image;
    logic                               has_left;
    logic                               has_up;
    logic [SLOT_W-1:0]                  slot;
    logic [BW-1:0]                      up_data;
    pngunf_pkg::t_neighbors             nb;
    logic [BW-1:0]                      value;
    logic                               bad_type;
    logic                               produce;
    pngunf_pkg::t_result                result;
    logic                               pop;
    logic [ADDR_W-1:0]                  n_col;
    logic [SLOT_W-1:0]                  n_col_mod;
    logic                               row_we;

    assign accept = i_byte_if.valid && i_byte_if.ready;
    assign pop    = r_out_valid && o_pix_if.ready;

    always_comb begin
        multi = r_color_mode && (MAX_CHANNELS > 1);

        if (r_image_width == '0) begin
            eff_width = pngunf_pkg::WIDTH_REG_W'(1);
        end else if (r_image_width > pngunf_pkg::WIDTH_REG_W'(WIDTH_CAP)) begin
            eff_width = pngunf_pkg::WIDTH_REG_W'(WIDTH_CAP);
        end else begin
            eff_width = r_image_width;
        end
        eff_height = (r_image_height == '0) ? HW'(1) : r_image_height;

        row_len   = multi ? LEN_W'(eff_width) * LEN_W'(MAX_CHANNELS)
                          : LEN_W'(eff_width);
        end_row   = (LEN_W'(r_col) + LEN_W'(1)) >= row_len;
        end_image = end_row && (({1'b0, r_row} + (HW + 1)'(1)) >= {1'b0, eff_height});

        has_left = multi ? (r_col >= ADDR_W'(MAX_CHANNELS)) : (r_col != '0);
        has_up   = r_row != '0;
        slot     = multi ? r_col_mod : '0;

        nb.left    = has_left ? r_left[slot] : '0;
        nb.up      = has_up ? up_data : '0;
        nb.up_left = (has_left && has_up) ? r_up_left[slot] : '0;

        bad_type = i_byte_if.stream_byte > BW'(pngunf_pkg::FILT_PAETH);
        produce  = !r_failed && (!r_await || bad_type);

        if (r_await) begin
            result = '{pixel_byte: '0, last_of_image: 1'b0, bad_filter: 1'b1};
        end else begin
            result = '{pixel_byte: value, last_of_image: end_image, bad_filter: 1'b0};
        end

        // Column that the next byte will use; the row memory is read there.
        n_col     = r_col;
        n_col_mod = r_col_mod;
        if (accept) begin
            if (r_await || end_row) begin
                n_col     = '0;
                n_col_mod = '0;
            end else begin
                n_col     = r_col + ADDR_W'(1);
                n_col_mod = (r_col_mod == SLOT_W'(MAX_CHANNELS - 1)) ? '0
                                                                   : r_col_mod + SLOT_W'(1);
            end
        end

        row_we = accept && !r_await && !r_failed;
    end

    pngunf_predictor u_predictor (
        .i_filter (r_row_filter),
        .i_nb     (nb),
        .i_byte   (i_byte_if.stream_byte),
        .o_value  (value)
    );

    pngunf_row_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_col),
        .i_wdata (value),
        .i_raddr (n_col),
        .o_rdata (up_data)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= pngunf_pkg::WIDTH_REG_W'(1);
            r_image_height <= HW'(1);
            r_color_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pngunf_pkg::CFG_IDX_WIDTH:
                    r_image_width <= i_cfg_data[pngunf_pkg::WIDTH_REG_W-1:0];
                pngunf_pkg::CFG_IDX_HEIGHT:
                    r_image_height <= i_cfg_data[HW-1:0];
                pngunf_pkg::CFG_IDX_COLOR:
                    r_color_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Row and image position tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_col_mod    <= '0;
            r_row        <= '0;
            r_row_filter <= pngunf_pkg::FILT_NONE;
            r_await      <= 1'b1;
            r_failed     <= 1'b0;
        end else if (accept) begin
            r_col     <= n_col;
            r_col_mod <= n_col_mod;
            if (r_await) begin
                r_await <= 1'b0;
                if (!r_failed) begin
                    if (bad_type) begin
                        r_failed <= 1'b1;
                    end else begin
                        r_row_filter <= pngunf_pkg::t_filter'(i_byte_if.stream_byte[2:0]);
                    end
                end
            end else if (end_row) begin
                r_await <= 1'b1;
                if (end_image) begin
                    r_row    <= '0;
                    r_failed <= 1'b0;
                end else begin
                    r_row <= r_row + HW'(1);
                end
            end
        end
    end

    // Left and upper-left history, one entry per channel, cleared at row start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_left[k]    <= '0;
                r_up_left[k] <= '0;
            end
        end else if (accept) begin
            if (r_await) begin
                for (int k = 0; k < MAX_CHANNELS; k++) begin
                    r_left[k]    <= '0;
                    r_up_left[k] <= '0;
                end
            end else if (!r_failed) begin
                r_left[slot]    <= value;
                r_up_left[slot] <= nb.up;
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (accept && produce) begin
            if (!r_out_valid || pop) begin
                r_out       <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_byte_if.ready        = !r_skid_valid;
    assign o_pix_if.valid         = r_out_valid;
    assign o_pix_if.pixel_byte    = r_out.pixel_byte;
    assign o_pix_if.last_of_image = r_out.last_of_image;
    assign o_pix_if.bad_filter    = r_out.bad_filter;

endmodule
